### sv/fpr_pkg.sv
package fpr_pkg;

   localparam int unsigned Width = 32;
   localparam int unsigned CntW  = $clog2(Width + 1);

   typedef enum logic [1:0] {
      REASON_TRIVIAL = 2'd0,
      REASON_FACTOR  = 2'd1,
      REASON_FERMAT  = 2'd2,
      REASON_PASS    = 2'd3
   } reason_type;

   // datapath operation selected by the controller
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_LOAD   = 4'd1,
      OP_REMST  = 4'd2,
      OP_REMBT  = 4'd3,
      OP_GSWAP  = 4'd4,
      OP_PINIT  = 4'd5,
      OP_MSTA   = 4'd6,
      OP_MSTS   = 4'd7,
      OP_MBIT   = 4'd8,
      OP_MEND   = 4'd9,
      OP_MENDS  = 4'd10,
      OP_ESHR   = 4'd11,
      OP_RELOAD = 4'd12
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic trivial;
      logic trivial_prime;
      logic y_zero;
      logic gcd_one;
      logic cnt_zero;
      logic e_zero;
      logic e_lsb;
      logic acc_one;
   } sts_type;

endpackage

### sv/fpr_datapath.sv
module fpr_datapath
   import fpr_pkg::*;
(
   input  logic                clock,
   input  logic [Width-1:0]    req_number,
   input  logic [Width-1:0]    req_base,
   input  cmd_type             cmd,
   output sts_type             sts
);

   logic [Width-1:0] n_ff, n_in;
   logic [Width-1:0] x_ff, x_in;     // gcd dividend / multiplicand
   logic [Width-1:0] y_ff, y_in;     // gcd divisor / multiplier
   logic [Width-1:0] r_ff, r_in;     // partial remainder / product accumulator
   logic [Width-1:0] q_ff, q_in;     // dividend bits still to shift in
   logic [Width-1:0] b_ff, b_in;     // raw base, then power base
   logic [Width-1:0] e_ff, e_in;     // exponent
   logic [Width-1:0] a_ff, a_in;     // power accumulator
   logic [CntW-1:0]  c_ff, c_in;

   logic [Width:0]   rsh;
   logic [Width:0]   rsub;
   logic [Width-1:0] rsh_mod;
   logic [Width-1:0] radd_mod;
   logic [Width:0]   radd;
   logic [Width:0]   xdbl;
   logic [Width-1:0] xdbl_mod;

   // one restoring division step: r = (r<<1 | msb of q) mod y
   assign rsh     = {r_ff, q_ff[Width-1]};
   assign rsub    = rsh - {1'b0, y_ff};
   assign rsh_mod = rsub[Width] ? rsh[Width-1:0] : rsub[Width-1:0];

   // modular add of x into r and doubling of x, modulus n
   assign radd     = {1'b0, r_ff} + {1'b0, x_ff};
   assign radd_mod = (radd >= {1'b0, n_ff}) ? Width'(radd - {1'b0, n_ff}) : radd[Width-1:0];
   assign xdbl     = {x_ff, 1'b0};
   assign xdbl_mod = (xdbl >= {1'b0, n_ff}) ? Width'(xdbl - {1'b0, n_ff}) : xdbl[Width-1:0];

   always_comb begin
      n_in = n_ff; x_in = x_ff; y_in = y_ff; r_in = r_ff; q_in = q_ff;
      b_in = b_ff; e_in = e_ff; a_in = a_ff; c_in = c_ff;
      case (cmd.op)
         // capture the beat; keep the raw base for the reduction pass
         OP_LOAD: begin
            n_in = req_number;
            x_in = req_number;
            y_in = req_base;
            b_in = req_base;
         end
         // set up base mod n from the held operands
         OP_RELOAD: begin
            x_in = b_ff;
            y_in = n_ff;
         end
         // start x mod y
         OP_REMST: begin
            r_in = '0;
            q_in = x_ff;
            c_in = CntW'(Width);
         end
         OP_REMBT: begin
            r_in = rsh_mod;
            q_in = {q_ff[Width-2:0], 1'b0};
            c_in = c_ff - 1'b1;
         end
         OP_GSWAP: begin
            x_in = y_ff;
            y_in = r_ff;
         end
         // base mod n is left in r by the remainder pass
         OP_PINIT: begin
            b_in = r_ff;
            e_in = n_ff - 1'b1;
            a_in = Width'(1);
         end
         // product a*b: x multiplicand, y multiplier
         OP_MSTA: begin
            x_in = a_ff; y_in = b_ff; r_in = '0;
            c_in = CntW'(Width);
         end
         OP_MSTS: begin
            x_in = b_ff; y_in = b_ff; r_in = '0;
            c_in = CntW'(Width);
         end
         OP_MBIT: begin
            if (y_ff[0]) r_in = radd_mod;
            x_in = xdbl_mod;
            y_in = {1'b0, y_ff[Width-1:1]};
            c_in = c_ff - 1'b1;
         end
         OP_MEND:  a_in = r_ff;
         OP_MENDS: b_in = r_ff;
         OP_ESHR:  e_in = {1'b0, e_ff[Width-1:1]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; x_ff <= x_in; y_ff <= y_in; r_ff <= r_in; q_ff <= q_in;
      b_ff <= b_in; e_ff <= e_in; a_ff <= a_in; c_ff <= c_in;
   end

   assign sts.trivial       = (n_ff <= Width'(4));
   assign sts.trivial_prime = (n_ff == Width'(2)) || (n_ff == Width'(3));
   assign sts.y_zero        = (y_ff == '0);
   assign sts.gcd_one       = (x_ff == Width'(1));
   assign sts.cnt_zero      = (c_ff == '0);
   assign sts.e_zero        = (e_ff == '0);
   assign sts.e_lsb         = e_ff[0];
   assign sts.acc_one       = (a_ff == Width'(1));

endmodule

### sv/fpr_control.sv
module fpr_control
   import fpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_probable_prime,
   output logic [1:0] rsp_reason,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CHECK = 10'b0000000010,
      ST_GDIV  = 10'b0000000100,
      ST_GNEXT = 10'b0000001000,
      ST_BRED  = 10'b0000010000,
      ST_PLOOP = 10'b0000100000,
      ST_MULA  = 10'b0001000000,
      ST_MULS  = 10'b0010000000,
      ST_SHR   = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       pp_ff, pp_in;
   logic [1:0] rs_ff, rs_in;
   logic       bred_ff, bred_in;   // remainder pass is the base reduction
   logic       req_accept;
   logic       finish;
   logic       fin_pp;
   reason_type fin_rs;

   assign req_stall  = (state_ff != ST_IDLE) || rv_ff;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      bred_in  = bred_ff;
      cmd.op   = OP_NONE;
      finish   = 1'b0;
      fin_pp   = 1'b0;
      fin_rs   = REASON_TRIVIAL;
      case (state_ff)
         ST_IDLE: if (req_accept) begin
            cmd.op   = OP_LOAD;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.trivial) begin
               finish = 1'b1;
               fin_pp = sts.trivial_prime;
            end else if (sts.y_zero) begin
               state_in = ST_GNEXT;
            end else begin
               cmd.op   = OP_REMST;
               bred_in  = 1'b0;
               state_in = ST_GDIV;
            end
         end
         ST_GDIV: begin
            if (sts.cnt_zero) begin
               if (bred_ff) begin
                  cmd.op   = OP_PINIT;
                  state_in = ST_PLOOP;
               end else begin
                  cmd.op   = OP_GSWAP;
                  state_in = ST_GNEXT;
               end
            end else begin
               cmd.op = OP_REMBT;
            end
         end
         // y zero ends Euclid; x holds the gcd
         ST_GNEXT: begin
            if (sts.y_zero) begin
               if (sts.gcd_one) begin
                  cmd.op   = OP_RELOAD;
                  state_in = ST_BRED;
               end else begin
                  finish = 1'b1;
                  fin_rs = REASON_FACTOR;
               end
            end else begin
               cmd.op   = OP_REMST;
               state_in = ST_GDIV;
            end
         end
         // reload has set x=base, y=n; reduce base mod n
         ST_BRED: begin
            cmd.op   = OP_REMST;
            bred_in  = 1'b1;
            state_in = ST_GDIV;
         end
         ST_PLOOP: begin
            if (sts.e_zero) begin
               finish = 1'b1;
               fin_pp = sts.acc_one;
               fin_rs = sts.acc_one ? REASON_PASS : REASON_FERMAT;
            end else if (sts.e_lsb) begin
               cmd.op   = OP_MSTA;
               state_in = ST_MULA;
            end else begin
               cmd.op   = OP_MSTS;
               state_in = ST_MULS;
            end
         end
         ST_MULA: begin
            if (sts.cnt_zero) begin
               cmd.op   = OP_MEND;
               state_in = ST_SHR;
            end else begin
               cmd.op = OP_MBIT;
            end
         end
         ST_SHR: begin
            cmd.op   = OP_MSTS;
            state_in = ST_MULS;
         end
         ST_MULS: begin
            if (sts.cnt_zero) begin
               cmd.op   = OP_MENDS;
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_MBIT;
            end
         end
         ST_DONE: begin
            cmd.op   = OP_ESHR;
            state_in = ST_PLOOP;
         end
         default: state_in = ST_IDLE;
      endcase
      if (finish) state_in = ST_IDLE;
   end

   // hold the result beat until taken
   always_comb begin
      rv_in = rv_ff;
      pp_in = pp_ff;
      rs_in = rs_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (finish) begin
         rv_in = 1'b1;
         pp_in = fin_pp;
         rs_in = fin_rs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      bred_ff <= bred_in;
      pp_ff   <= pp_in;
      rs_ff   <= rs_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_probable_prime = pp_ff;
   assign rsp_reason         = rs_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == ST_IDLE)
      else $error("result pending while busy");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_accept)
      else $error("item taken while busy");
   a_pass_prime: assert property (@(posedge clock) disable iff (reset)
      rv_ff && (rs_ff == REASON_PASS) |-> pp_ff)
      else $error("pass without prime flag");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      finish |=> rv_ff)
      else $error("verdict lost");

endmodule

### sv/fermat_primality_round.sv
// One Fermat round per item: for number n and base b the block answers
// composite for n in 0, 1, 4 and prime for 2, 3 (reason 0); otherwise it runs
// Euclid's gcd (reason 1 if not 1), then b^(n-1) mod n by square-and-multiply
// (reason 2 if not 1, else reason 3 and probable_prime set). One item is in
// work at a time. Each gcd remainder runs on a bit-serial shift-subtract
// unit, the base reduction on the same unit, and each exponent bit does a
// multiply when the bit is set, then a square, plus loop overhead. Small
// trivial numbers are decided in the check right after loading, without gcd.
module fermat_primality_round
   import fpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_number,
   input  logic [31:0] req_base,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_probable_prime,
   output logic [1:0]  rsp_reason
);

   cmd_type cmd;
   sts_type sts;

   fpr_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_probable_prime, .rsp_reason, .cmd, .sts
   );

   fpr_datapath u_datapath (
      .clock,
      .req_number (req_number[Width-1:0]),
      .req_base   (req_base[Width-1:0]),
      .cmd,
      .sts
   );

endmodule
